@@ sv/batch_position_scheduler_assert.svh @@
// Assertion helpers for the batch position scheduler.
// Each macro checks a property on the rising clock edge, with reset held off.
`ifndef BATCH_POSITION_SCHEDULER_ASSERT_SVH
`define BATCH_POSITION_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("batch_position_scheduler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("batch_position_scheduler: next-cycle check failed");

`endif

@@ sv/bps_pkg.sv @@
`default_nettype none

package bps_pkg;

  // Request codes carried by the action field.
  typedef enum logic [2:0] {
    ACT_ISSUE     = 3'd0,
    ACT_TAKE      = 3'd1,
    ACT_FINISH    = 3'd2,
    ACT_SET_SYNC  = 3'd3,
    ACT_GET_SYNC  = 3'd4,
    ACT_WAIT_FIN  = 3'd5,
    ACT_WAIT_SYNC = 3'd6,
    ACT_STOP      = 3'd7
  } action_e;

  // Answer codes carried by the status field.
  typedef enum logic [1:0] {
    STAT_GRANTED = 2'd0,
    STAT_WAIT    = 2'd1,
    STAT_STOPPED = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LIST_LENGTH   = 2'd0,
    REG_SLOT_LENGTH   = 2'd1,
    REG_BATCH_LENGTH  = 2'd2,
    REG_MAX_IN_FLIGHT = 2'd3
  } reg_idx_e;

  // Configuration reset values.
  localparam logic [15:0] LIST_LENGTH_RST   = 16'd1024;
  localparam logic [15:0] SLOT_LENGTH_RST   = 16'd64;
  localparam logic [15:0] BATCH_LENGTH_RST  = 16'd8;
  localparam logic [15:0] MAX_IN_FLIGHT_RST = 16'd4;

  // Status of the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } bps_div_stat_t;

endpackage

`default_nettype wire

@@ sv/bps_div.sv @@
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module bps_div import bps_pkg::*; #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [15:0]      divisor_i,
  output bps_div_stat_t         stat_o,
  output logic [15:0]           rem_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH-1:0] num_q;
  logic [15:0]      rem_q;
  logic [15:0]      den_q;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, num_q[WIDTH-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  // Sequencing of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(WIDTH);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and shifting dividend.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fits ? diff[15:0] : trial[15:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

@@ sv/batch_position_scheduler.sv @@
// Batch position scheduler: tracks the issued, taken, finished and synced
// positions of a recycled work list, plus a running flag.
// Requests enter on the in channel (valid/ready): action, amount and target.
// One result word leaves on the out channel (valid/ready) per request, with
// a status (granted, wait, stopped), a slot base and a task position.
// The block takes one request at a time; in_ready_o is low while it works.
// Requests that need no slot base go through ST_EXEC and ST_DONE only.
// A take runs one serial remainder pass over the slot length; a get sync
// runs two passes, one for the synced position and one for the picked
// position. The remainder unit works one dividend bit per cycle.
// A finished result sits in an output register; while the receiver stalls
// the next request is still accepted and worked on, and it waits at the end
// until the register is free. Reset sets all positions to -1, sets running,
// and loads the register defaults. Registers are on an APB-style port.
`default_nettype none

module batch_position_scheduler import bps_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [15:0]        amount_i,
  input  wire logic signed [16:0] target_position_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [15:0]             slot_base_o,
  output logic [15:0]             task_position_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned AW = PW + 19;

  typedef logic signed [AW-1:0] wide_t;
  typedef logic signed [PW:0]   pos_t;

  localparam wide_t MINUS_ONE_W = '1;
  localparam wide_t POS_MAX_W   = wide_t'({PW{1'b1}});

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_DIV1 = 6'b000100,
    ST_PICK = 6'b001000,
    ST_DIV2 = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  // Clamp a position to the range from -1 to the largest position.
  function automatic wide_t sat_pos(input wide_t v);
    wide_t r;
    r = v;
    if (v < MINUS_ONE_W) r = MINUS_ONE_W;
    if (v > POS_MAX_W) r = POS_MAX_W;
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] list_q, slot_q, batch_q, mif_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_q  <= LIST_LENGTH_RST;
      slot_q  <= SLOT_LENGTH_RST;
      batch_q <= BATCH_LENGTH_RST;
      mif_q   <= MAX_IN_FLIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_LIST_LENGTH:   list_q  <= pwdata[15:0];
        REG_SLOT_LENGTH:   slot_q  <= pwdata[15:0];
        REG_BATCH_LENGTH:  batch_q <= pwdata[15:0];
        REG_MAX_IN_FLIGHT: mif_q   <= pwdata[15:0];
        default:           list_q  <= list_q;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_LIST_LENGTH:   prdata = {16'd0, list_q};
      REG_SLOT_LENGTH:   prdata = {16'd0, slot_q};
      REG_BATCH_LENGTH:  prdata = {16'd0, batch_q};
      REG_MAX_IN_FLIGHT: prdata = {16'd0, mif_q};
      default:           prdata = '0;
    endcase
  end

  // Sequencer and position state.
  state_e          state_q, state_d;
  action_e         action_q, action_d;
  logic [15:0]     amount_q, amount_d;
  logic signed [16:0] target_q, target_d;
  pos_t            issued_q, issued_d;
  pos_t            taken_q, taken_d;
  pos_t            finished_q, finished_d;
  pos_t            synced_q, synced_d;
  logic            running_q, running_d;
  logic [PW-1:0]   p_q, p_d;
  wide_t           ceil_q, ceil_d;
  status_e         res_status_q, res_status_d;
  logic [15:0]     res_base_q, res_base_d;
  logic [15:0]     res_task_q, res_task_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  logic [15:0]     out_base_q, out_base_d;
  logic [15:0]     out_task_q, out_task_d;

  // Shared remainder unit.
  logic            div_start;
  logic [PW-1:0]   div_dividend;
  logic [15:0]     slot_eff;
  bps_div_stat_t   div_stat;
  logic [15:0]     div_rem;

  assign slot_eff = (slot_q == 16'd0) ? 16'd1 : slot_q;

  bps_div #(
    .WIDTH (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (slot_eff),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  // Widened views of the state for compares and sums.
  wide_t iss_w, tak_w, fin_w, syn_w, amt_w, tgt_sat;
  wide_t sum_iss, new_iss, fin_new, take_next;
  wide_t p_w, rem_w, base_w, slot_w;
  wide_t sync_batch, done_w, pick_w;
  logic  wrap, issue_wait;

  assign iss_w   = wide_t'(issued_q);
  assign tak_w   = wide_t'(taken_q);
  assign fin_w   = wide_t'(finished_q);
  assign syn_w   = wide_t'(synced_q);
  assign amt_w   = wide_t'(amount_q);
  assign tgt_sat = sat_pos(wide_t'(target_q));
  assign slot_w  = wide_t'(slot_eff);

  // Issue checks: recycle at the list end once synced has caught up with
  // issued, in-flight limit for single issues.
  assign sum_iss    = iss_w + amt_w;
  assign wrap       = (sum_iss >= wide_t'(list_q));
  assign issue_wait = (wrap && (syn_w < iss_w)) ||
                      ((amount_q == 16'd1) && (iss_w >= fin_w + wide_t'(mif_q)));
  assign new_iss    = wrap ? sat_pos(MINUS_ONE_W + amt_w) : sat_pos(sum_iss);
  assign fin_new    = sat_pos(fin_w + amt_w);
  assign take_next  = tak_w + wide_t'(1);

  // Slot base of the current dividend once its remainder is known.
  assign p_w    = wide_t'(p_q);
  assign rem_w  = wide_t'(div_rem);
  assign base_w = p_w - rem_w;

  // Sync pick: at most one batch ahead, never past the finished position,
  // and stopping at the end of the slot that holds the synced position.
  assign sync_batch = syn_w + wide_t'(batch_q);
  assign done_w     = (sync_batch < fin_w) ? sync_batch : fin_w;
  always_comb begin
    pick_w = done_w;
    if ((syn_w < ceil_q) && (done_w > ceil_q)) pick_w = ceil_q;
    if (pick_w < 0) pick_w = '0;
  end

  always_comb begin
    state_d      = state_q;
    action_d     = action_q;
    amount_d     = amount_q;
    target_d     = target_q;
    issued_d     = issued_q;
    taken_d      = taken_q;
    finished_d   = finished_q;
    synced_d     = synced_q;
    running_d    = running_q;
    p_d          = p_q;
    ceil_d       = ceil_q;
    res_status_d = res_status_q;
    res_base_d   = res_base_q;
    res_task_d   = res_task_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_base_d   = out_base_q;
    out_task_d   = out_task_q;
    div_start    = 1'b0;
    div_dividend = p_q;

    // The receiver took the pending word.
    if (out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          action_d = action_e'(action_i);
          amount_d = amount_i;
          target_d = target_position_i;
          state_d  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_status_d = STAT_GRANTED;
        res_base_d   = '0;
        res_task_d   = '0;
        state_d      = ST_DONE;
        unique case (action_q)
          ACT_ISSUE: begin
            if (!running_q) begin
              res_status_d = STAT_STOPPED;
            end else if (issue_wait) begin
              res_status_d = STAT_WAIT;
            end else begin
              if (wrap) begin
                taken_d    = '1;
                finished_d = '1;
                synced_d   = '1;
              end
              issued_d = new_iss[PW:0];
            end
          end
          ACT_TAKE: begin
            if (!running_q) begin
              res_status_d = STAT_STOPPED;
            end else if (tak_w >= iss_w) begin
              res_status_d = STAT_WAIT;
            end else begin
              taken_d      = take_next[PW:0];
              p_d          = take_next[PW-1:0];
              div_start    = 1'b1;
              div_dividend = take_next[PW-1:0];
              state_d      = ST_DIV1;
            end
          end
          ACT_FINISH: begin
            finished_d = fin_new[PW:0];
          end
          ACT_SET_SYNC: begin
            synced_d = tgt_sat[PW:0];
          end
          ACT_GET_SYNC: begin
            if (!running_q) begin
              res_status_d = STAT_STOPPED;
            end else if (syn_w >= fin_w) begin
              res_status_d = STAT_WAIT;
            end else begin
              // A synced position of -1 lies in the slot starting at 0.
              p_d          = (syn_w < 0) ? '0 : synced_q[PW-1:0];
              div_start    = 1'b1;
              div_dividend = (syn_w < 0) ? '0 : synced_q[PW-1:0];
              state_d      = ST_DIV1;
            end
          end
          ACT_WAIT_FIN: begin
            if (!running_q) res_status_d = STAT_STOPPED;
            else if (fin_w < tgt_sat) res_status_d = STAT_WAIT;
          end
          ACT_WAIT_SYNC: begin
            if (!running_q) res_status_d = STAT_STOPPED;
            else if (syn_w < tgt_sat) res_status_d = STAT_WAIT;
          end
          ACT_STOP: begin
            running_d = 1'b0;
          end
          default: begin
            running_d = 1'b0;
          end
        endcase
      end

      ST_DIV1: begin
        if (div_stat.done) begin
          if (action_q == ACT_GET_SYNC) begin
            // Last task of the slot holding the synced position.
            ceil_d  = base_w + slot_w - wide_t'(1);
            state_d = ST_PICK;
          end else begin
            res_base_d = base_w[15:0];
            res_task_d = p_w[15:0];
            state_d    = ST_DONE;
          end
        end
      end

      ST_PICK: begin
        p_d          = pick_w[PW-1:0];
        div_start    = 1'b1;
        div_dividend = pick_w[PW-1:0];
        state_d      = ST_DIV2;
      end

      ST_DIV2: begin
        if (div_stat.done) begin
          res_base_d = base_w[15:0];
          res_task_d = p_w[15:0];
          state_d    = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_base_d   = res_base_q;
          out_task_d   = res_task_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and position state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= '1;
      taken_q     <= '1;
      finished_q  <= '1;
      synced_q    <= '1;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      taken_q     <= taken_d;
      finished_q  <= finished_d;
      synced_q    <= synced_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request, working and result words.
  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    amount_q     <= amount_d;
    target_q     <= target_d;
    p_q          <= p_d;
    ceil_q       <= ceil_d;
    res_status_q <= res_status_d;
    res_base_q   <= res_base_d;
    res_task_q   <= res_task_d;
    out_status_q <= out_status_d;
    out_base_q   <= out_base_d;
    out_task_q   <= out_task_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_base_o     = out_base_q;
  assign task_position_o = out_task_q;

  // A refused request carries zero in both position fields.
  logic out_refused;
  logic out_fields_zero;

  assign out_refused     = out_valid_o && (out_status_q != STAT_GRANTED);
  assign out_fields_zero = (slot_base_o == 16'd0) && (task_position_o == 16'd0);

  // Checks on the sequencer and the position state.
`include "batch_position_scheduler_assert.svh"

  `BPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `BPS_ASSERT_NOW(a_zero_unless_granted, out_refused, out_fields_zero)
  `BPS_ASSERT_NOW(a_taken_not_past_issued, 1'b1, taken_q <= issued_q)
  `BPS_ASSERT_NOW(a_divider_quiet_in_idle, state_q == ST_IDLE, !div_stat.busy)

endmodule

`default_nettype wire
